// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define DLTA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define DLTA_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  `DLTA_ASSERT(lbl, clk, rst_n, !(expr), msg)

`endif

// File: design/dlta_pkg.sv
// ----------------------------------------------------------------------------
// dlta_pkg
// Types and constants of the lease table allocator.
// ----------------------------------------------------------------------------
package dlta_pkg;

  localparam int LEASE_SLOTS = 8;
  localparam int FIRST_HOST  = 16;
  localparam int SLOT_W      = (LEASE_SLOTS > 1) ? $clog2(LEASE_SLOTS) : 1;

  localparam int MAC_W      = 48;
  localparam int TIME_W     = 32;
  localparam int MARK_W     = 16;
  localparam int ADDR_W     = 32;
  localparam int OUT_SLOT_W = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 40;

  localparam logic [ADDR_W-1:0] SERVER_ADDRESS_RST = 32'hC0A8_0401;
  localparam logic [TIME_W-1:0] LEASE_DURATION_RST = 32'd86_400_000;

  localparam logic [CFG_IDX_W-1:0] REG_SERVER_ADDRESS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEASE_DURATION = 8'd1;

  localparam logic CMD_DISCOVER = 1'b0;
  localparam logic CMD_REQUEST  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OFFER = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ACK   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NONE  = 2'd2;

  typedef struct packed {
    logic              valid;
    logic              cmd;
    logic [MAC_W-1:0]  mac;
    logic [TIME_W-1:0] now;
    logic              found;
    logic [SLOT_W-1:0] found_slot;
    logic              free_ok;
    logic [SLOT_W-1:0] free_slot;
  } token_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] slot;
    logic [MAC_W-1:0]  mac;
    logic [MARK_W-1:0] expiry;
  } commit_t;

endpackage

// File: design/dlta_cell.sv
// ----------------------------------------------------------------------------
// dlta_cell
// One lease slot: checks the passing lookup item against its MAC and expiry
// mark, frees an expired lease on discover, and takes the final write.
// ----------------------------------------------------------------------------
module dlta_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [dlta_pkg::SLOT_W-1:0] idx_i,
  input  dlta_pkg::token_t        tok_i,
  output dlta_pkg::token_t        tok_o,
  input  dlta_pkg::commit_t       commit_i
);
  import dlta_pkg::*;

  logic [MAC_W-1:0]  mac_q, mac_d;
  logic [MARK_W-1:0] exp_q, exp_d;
  token_t            tok_q, tok_d;

  logic              match, is_free, expired, claimable;
  logic [MARK_W-1:0] diff;
  logic [TIME_W-1:0] claim_diff;

  always_comb begin
    match      = (mac_q == tok_i.mac);
    is_free    = (mac_q == '0);
    diff       = tok_i.now[TIME_W-1:MARK_W] - exp_q;
    expired    = !is_free && (exp_q != '0) && (diff != '0) && !diff[MARK_W-1];
    claim_diff = {exp_q, {MARK_W{1'b1}}} - tok_i.now;
    claimable  = is_free || claim_diff[TIME_W-1];

    tok_d = tok_i;
    mac_d = mac_q;
    exp_d = exp_q;

    if (tok_i.valid) begin
      if (tok_i.cmd == CMD_DISCOVER) begin
        if (!tok_i.found) begin
          if (match) begin
            tok_d.found      = 1'b1;
            tok_d.found_slot = idx_i;
          end else if (is_free) begin
            if (!tok_i.free_ok) begin
              tok_d.free_ok   = 1'b1;
              tok_d.free_slot = idx_i;
            end
          end else if (expired) begin
            mac_d = '0;
            exp_d = '0;
            if (!tok_i.free_ok) begin
              tok_d.free_ok   = 1'b1;
              tok_d.free_slot = idx_i;
            end
          end
        end
      end else begin
        if (!tok_i.found && match) begin
          tok_d.found      = 1'b1;
          tok_d.found_slot = idx_i;
        end
        if (!tok_i.free_ok && claimable) begin
          tok_d.free_ok   = 1'b1;
          tok_d.free_slot = idx_i;
        end
      end
    end

    if (commit_i.we && (commit_i.slot == idx_i)) begin
      mac_d = commit_i.mac;
      exp_d = commit_i.expiry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mac_q <= '0;
      exp_q <= '0;
      tok_q <= '0;
    end else begin
      mac_q <= mac_d;
      exp_q <= exp_d;
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: design/dhcp_lease_table_allocator.sv
// ----------------------------------------------------------------------------
// dhcp_lease_table_allocator
// Lease slot allocation for a DHCP server: discover offers, request acks.
// ----------------------------------------------------------------------------
// Usage: a lookup item enters on the s_axis channel (tuser = cmd, discover or
// request). It walks a row of lease cells, one slot per cycle, and one result
// item leaves on the m_axis channel (tuser = status: offer, ack or no address).
// The item passes each cell register in turn, then the result register, and
// then the output register that drives tvalid on the result side.
// One item is in the row at a time, so a new item is taken once the previous
// result has moved into the output register. A stalled receiver holds the
// output register; one finished result more waits inside, and after that
// s_axis_tready stays low.
// The cfg channel writes server_address (index 0) or lease_duration_ms
// (index 1); other indexes are ignored. It is always ready; the user must
// write it only while no item is in flight, which the block does not enforce.
// Reset clears every slot (MAC and expiry zero, slot free) and restores the
// register defaults 192.168.4.1 and 86400000 ms.
// ----------------------------------------------------------------------------
module dhcp_lease_table_allocator (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // cfg write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dlta_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dlta_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // lookup items
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [47:0] client_mac, [79:48] now_ms, [80] broadcast_requested,
  // [81] client_has_address, [87:82] zero
  input  logic [dlta_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [0] cmd
  input  logic                            s_axis_tuser_i,
  // result items
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [2:0] slot, [34:3] offered_address, [35] send_unicast, [39:36] zero
  output logic [dlta_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  // [1:0] status
  output logic [dlta_pkg::STATUS_W-1:0]   m_axis_tuser_o
);
  import dlta_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_RES  = 4'b0100,
    S_HOLD = 4'b1000
  } state_e;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [ADDR_W-1:0]     addr;
    logic                  unicast;
  } result_t;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] srv_addr_q;
  logic [TIME_W-1:0] lease_dur_q;

  logic    bcast_q, has_addr_q;
  logic    s_accept, m_load;
  token_t  tok_in;
  token_t  tok_chain [LEASE_SLOTS+1];
  logic [LEASE_SLOTS-1:0] tok_valid;
  token_t  tok_last;

  commit_t commit_q, commit_d;
  result_t res_q, res_d;
  result_t out_q;
  logic    out_valid_q;

  logic                  sel_ok;
  logic [SLOT_W-1:0]     sel_slot;
  logic [SLOT_W+2:0]     sel_ext;
  logic [7:0]            host;
  logic [TIME_W-1:0]     new_end;

  // cfg
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      srv_addr_q  <= SERVER_ADDRESS_RST;
      lease_dur_q <= LEASE_DURATION_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_SERVER_ADDRESS: srv_addr_q  <= cfg_data_i;
        REG_LEASE_DURATION: lease_dur_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input side
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    tok_in            = '0;
    tok_in.valid      = s_accept;
    tok_in.cmd        = s_axis_tuser_i;
    tok_in.mac        = s_axis_tdata_i[47:0];
    tok_in.now        = s_axis_tdata_i[79:48];
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      bcast_q    <= s_axis_tdata_i[80];
      has_addr_q <= s_axis_tdata_i[81];
    end
  end

  // cell row
  assign tok_chain[0] = tok_in;

  for (genvar g = 0; g < LEASE_SLOTS; g++) begin : g_cell
    dlta_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .idx_i    (SLOT_W'(g)),
      .tok_i    (tok_chain[g]),
      .tok_o    (tok_chain[g+1]),
      .commit_i (commit_q)
    );
    assign tok_valid[g] = tok_chain[g+1].valid;
  end

  assign tok_last = tok_chain[LEASE_SLOTS];

  // result and write-back
  always_comb begin
    sel_ok   = tok_last.found || tok_last.free_ok;
    sel_slot = tok_last.found ? tok_last.found_slot : tok_last.free_slot;
    sel_ext  = {3'b000, sel_slot};
    host     = 8'(FIRST_HOST) + 8'(sel_ext);
    new_end  = tok_last.now + lease_dur_q;

    commit_d        = '0;
    commit_d.we     = tok_last.valid && sel_ok && (tok_last.cmd == CMD_REQUEST);
    commit_d.slot   = sel_slot;
    commit_d.mac    = tok_last.mac;
    commit_d.expiry = new_end[TIME_W-1:MARK_W];

    res_d = '0;
    if (sel_ok) begin
      res_d.status  = (tok_last.cmd == CMD_REQUEST) ? ST_ACK : ST_OFFER;
      res_d.slot    = sel_ext[OUT_SLOT_W-1:0];
      res_d.addr    = {srv_addr_q[ADDR_W-1:8], host};
      res_d.unicast = (tok_last.cmd == CMD_REQUEST) && !bcast_q && !has_addr_q;
    end else begin
      res_d.status = ST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      commit_q <= '0;
    end else begin
      commit_q <= commit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tok_last.valid) begin
      res_q <= res_d;
    end
  end

  // sequencer
  assign m_load = (state_q == S_HOLD) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (s_accept) state_d = S_WALK;
      S_WALK: if (tok_last.valid) state_d = S_RES;
      S_RES:  state_d = S_HOLD;
      S_HOLD: if (m_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (m_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_load) begin
      out_q <= res_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {4'b0000, out_q.unicast, out_q.addr, out_q.slot};

  // checks
  `DLTA_ASSERT(a_one_item_in_row, clk_i, rst_ni, $onehot0(tok_valid),
    "more than one item in the cell row")
  `DLTA_ASSERT(a_exit_in_walk, clk_i, rst_ni, tok_last.valid |-> state_q == S_WALK,
    "item left the cell row outside the walk")
  `DLTA_ASSERT(a_commit_after_exit, clk_i, rst_ni, commit_q.we |-> state_q == S_RES,
    "slot write outside the result cycle")
  `DLTA_ASSERT_NEVER(a_none_zero_fields, clk_i, rst_ni,
    out_valid_q && out_q.status == ST_NONE && m_axis_tdata_o != '0,
    "no-address result with nonzero fields")

endmodule

// File: dv/dhcp_lease_table_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dhcp_lease_table_allocator_test
// Self-checking bench for the lease table allocator. Lookup items (discover
// and request) go in on the slave stream and one reply per item comes back on
// the master stream. A lease table kept inside the bench predicts every reply:
// the slot offered or acknowledged, the address, the unicast flag, or a full
// pool. Directed tests cover defaults, client flags, zero MAC, a full pool,
// both expiry rules and register extremes. Random traffic then replays
// discover/request pairs from a small MAC pool with advancing time, mixed
// with noise, under three sender/receiver stall profiles.
// ----------------------------------------------------------------------------
module dhcp_lease_table_allocator_test;
  import dlta_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [OUT_SLOT_W-1:0] slot;
    logic [ADDR_W-1:0]     addr;
    logic                  unicast;
  } lease_reply_t;

  localparam logic [MAC_W-1:0] MAC_ALPHA = 48'h02_00_5E_10_00_01;
  localparam logic [MAC_W-1:0] MAC_BRAVO = 48'h02_00_5E_20_00_01;
  localparam logic [MAC_W-1:0] MAC_CHARLIE = 48'h02_00_5E_30_00_01;
  localparam logic [MAC_W-1:0] MAC_ONES = 48'hFFFF_FFFF_FFFF;
  localparam int SETTLE_CYCLES = 4 * (LEASE_SLOTS + 3);

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    s_axis_tvalid_i = 1'b0;
  logic                    s_axis_tready_o;
  logic [IN_DATA_W-1:0]    s_axis_tdata_i = '0;
  logic                    s_axis_tuser_i = 1'b0;
  logic                    m_axis_tvalid_o;
  logic                    m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0]   m_axis_tdata_o;
  logic [STATUS_W-1:0]     m_axis_tuser_o;

  logic [MAC_W-1:0]  slot_mac [LEASE_SLOTS];
  logic [MARK_W-1:0] slot_mark [LEASE_SLOTS];
  logic [ADDR_W-1:0] server_ip = SERVER_ADDRESS_RST;
  logic [TIME_W-1:0] lease_len_ms = LEASE_DURATION_RST;

  lease_reply_t      pending_replies [$];
  logic [MAC_W-1:0]  client_pool [16];
  logic [TIME_W-1:0] clock_ms = '0;
  int                src_idle_pct = 0;
  int                snk_idle_pct = 0;
  int                fail_count = 0;

  dhcp_lease_table_allocator u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic lease_reply_t predict_lease_reply(logic cmd, logic [MAC_W-1:0] mac,
                                                       logic [TIME_W-1:0] now, logic bcast,
                                                       logic has_addr);
    int                hit;
    int                free_idx;
    int                i;
    bit                done;
    logic [MARK_W-1:0] age;
    logic [TIME_W-1:0] margin;
    logic [TIME_W-1:0] lease_end;
    logic [7:0]        host;
    lease_reply_t      reply;
    hit = -1;
    free_idx = -1;
    done = 1'b0;
    if (cmd == CMD_DISCOVER) begin
      for (i = 0; i < LEASE_SLOTS; i++) begin
        if (!done) begin
          if (slot_mac[i] == mac) begin
            hit = i;
            done = 1'b1;
          end else if (slot_mac[i] == '0) begin
            if (free_idx < 0) free_idx = i;
          end else begin
            age = now[31:16] - slot_mark[i];
            if (age != '0 && age < 16'h8000 && slot_mark[i] != '0) begin
              slot_mac[i] = '0;
              slot_mark[i] = '0;
              if (free_idx < 0) free_idx = i;
            end
          end
        end
      end
      if (hit < 0) hit = free_idx;
    end else begin
      for (i = 0; i < LEASE_SLOTS; i++) begin
        if (!done && slot_mac[i] == mac) begin
          hit = i;
          done = 1'b1;
        end
      end
      for (i = 0; i < LEASE_SLOTS; i++) begin
        margin = {slot_mark[i], 16'hFFFF} - now;
        if (!done && (slot_mac[i] == '0 || margin[31])) begin
          slot_mac[i] = mac;
          hit = i;
          done = 1'b1;
        end
      end
      if (hit >= 0) begin
        lease_end = now + lease_len_ms;
        slot_mark[hit] = lease_end[31:16];
      end
    end
    if (hit < 0) begin
      reply = '0;
      reply.status = ST_NONE;
    end else begin
      host = 8'(FIRST_HOST + hit);
      reply.status = (cmd == CMD_REQUEST) ? ST_ACK : ST_OFFER;
      reply.slot = OUT_SLOT_W'(hit);
      reply.addr = {server_ip[31:8], host};
      reply.unicast = (cmd == CMD_REQUEST) && !bcast && !has_addr;
    end
    return reply;
  endfunction

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[MAC_W-1:0];
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    lease_reply_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_replies.size() == 0) begin
        $display("%0t ns: unexpected reply, expected none, actual %h/%h", $time,
                 m_axis_tuser_o, m_axis_tdata_o);
        fail_count++;
      end else begin
        want = pending_replies.pop_front();
        check_field("status", 32'(want.status), 32'(m_axis_tuser_o));
        check_field("slot", 32'(want.slot), 32'(m_axis_tdata_o[2:0]));
        check_field("offered_address", want.addr, m_axis_tdata_o[34:3]);
        check_field("send_unicast", 32'(want.unicast), 32'(m_axis_tdata_o[35]));
        check_field("pad", 32'd0, 32'(m_axis_tdata_o[39:36]));
      end
    end
    m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  task automatic send_lookup(logic cmd, logic [MAC_W-1:0] mac, logic [TIME_W-1:0] now,
                             logic bcast, logic has_addr);
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= cmd;
    s_axis_tdata_i <= {6'b0, has_addr, bcast, now, mac};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    pending_replies.push_back(predict_lease_reply(cmd, mac, now, bcast, has_addr));
  endtask

  task automatic settle_lookups();
    if (s_axis_tvalid_i) s_axis_tvalid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    settle_lookups();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_SERVER_ADDRESS) server_ip = value;
    else if (idx == REG_LEASE_DURATION) lease_len_ms = value;
  endtask

  task automatic test_offer_and_ack();
    send_lookup(CMD_DISCOVER, MAC_ALPHA, 32'd0, 1'b0, 1'b0);
    send_lookup(CMD_REQUEST, MAC_ALPHA, 32'd0, 1'b0, 1'b0);
    send_lookup(CMD_REQUEST, MAC_ALPHA, 32'd0, 1'b1, 1'b0);
    send_lookup(CMD_REQUEST, MAC_ALPHA, 32'd0, 1'b0, 1'b1);
    send_lookup(CMD_REQUEST, MAC_ALPHA, 32'd0, 1'b1, 1'b1);
  endtask

  task automatic test_zero_mac();
    send_lookup(CMD_DISCOVER, '0, 32'd0, 1'b0, 1'b0);
    send_lookup(CMD_REQUEST, '0, 32'd0, 1'b0, 1'b0);
  endtask

  task automatic test_pool_full();
    for (int i = 1; i < LEASE_SLOTS; i++) begin
      send_lookup(CMD_REQUEST, MAC_BRAVO + i, 32'd0, 1'b0, 1'b0);
    end
    send_lookup(CMD_REQUEST, MAC_CHARLIE, 32'd0, 1'b0, 1'b0);
    send_lookup(CMD_DISCOVER, MAC_CHARLIE, 32'd0, 1'b0, 1'b0);
  endtask

  task automatic test_expiry();
    send_lookup(CMD_DISCOVER, MAC_CHARLIE, 32'h0600_0000, 1'b0, 1'b0);
    write_register(REG_LEASE_DURATION, 32'd0);
    send_lookup(CMD_REQUEST, MAC_BRAVO, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_lookup(CMD_REQUEST, MAC_CHARLIE, 32'h0001_0000, 1'b0, 1'b0);
  endtask

  task automatic test_register_extremes();
    write_register(REG_SERVER_ADDRESS, 32'hFFFF_FFFF);
    write_register(REG_LEASE_DURATION, 32'hFFFF_FFFF);
    send_lookup(CMD_REQUEST, MAC_ONES, 32'hFFFF_FFFF, 1'b1, 1'b1);
    write_register(REG_SERVER_ADDRESS, 32'd0);
    send_lookup(CMD_DISCOVER, MAC_ONES, 32'd0, 1'b0, 1'b0);
    write_register(8'hA5, 32'h1234_5678);
    send_lookup(CMD_DISCOVER, MAC_ONES, 32'd0, 1'b0, 1'b0);
    write_register(REG_SERVER_ADDRESS, SERVER_ADDRESS_RST);
    write_register(REG_LEASE_DURATION, LEASE_DURATION_RST);
  endtask

  task automatic run_lease_traffic(int n_items, int src_pct, int snk_pct);
    int sent;
    int pick;
    int roll;
    logic [MAC_W-1:0] mac;
    sent = 0;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    while (sent < n_items) begin
      write_register(REG_SERVER_ADDRESS, $urandom());
      if ($urandom_range(9) < 8) begin
        write_register(REG_LEASE_DURATION, $urandom_range(32'h0080_0000, 32'h0001_0000));
      end else begin
        write_register(REG_LEASE_DURATION, $urandom());
      end
      for (int k = 0; k < 110 && sent < n_items; k++) begin
        pick = $urandom_range(15);
        roll = $urandom_range(99);
        if (roll < 65) begin
          send_lookup(CMD_DISCOVER, client_pool[pick], clock_ms, 1'($urandom()),
                      1'($urandom()));
          clock_ms += $urandom_range(2000);
          send_lookup(CMD_REQUEST, client_pool[pick], clock_ms, 1'($urandom()),
                      1'($urandom()));
          sent += 2;
        end else if (roll < 85) begin
          send_lookup(CMD_REQUEST, client_pool[pick], clock_ms, 1'($urandom()),
                      1'($urandom()));
          sent++;
        end else if (roll < 92) begin
          send_lookup(CMD_DISCOVER, client_pool[pick], clock_ms, 1'($urandom()),
                      1'($urandom()));
          sent++;
        end else begin
          mac = ($urandom_range(7) == 0) ? '0 : random_mac();
          send_lookup(1'($urandom()), mac, $urandom(), 1'($urandom()), 1'($urandom()));
          sent++;
        end
        if ($urandom_range(19) == 0) clock_ms = $urandom();
        else clock_ms += $urandom_range(32'h0003_0000);
      end
    end
  endtask

  initial begin
    for (int i = 0; i < LEASE_SLOTS; i++) begin
      slot_mac[i] = '0;
      slot_mark[i] = '0;
    end
    for (int i = 0; i < 16; i++) client_pool[i] = random_mac();
    src_idle_pct = 14;
    snk_idle_pct = 79;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_offer_and_ack();
    test_zero_mac();
    test_pool_full();
    test_expiry();
    test_register_extremes();
    run_lease_traffic(340, 14, 79);
    run_lease_traffic(330, 79, 14);
    run_lease_traffic(330, 0, 0);
    settle_lookups();
    if (cfg_valid_i) cfg_valid_i <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+design
design/dlta_pkg.sv
design/dlta_cell.sv
design/dhcp_lease_table_allocator.sv
dv/dhcp_lease_table_allocator_test.sv
